// File: src/bfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_pkg: shared definitions for the bitmap frame allocator
// Field widths, request codes, map word geometry and the bit search helper.
// ----------------------------------------------------------------------------
package bfa_pkg;

  // Field widths
  localparam int FRAME_W = 16;
  localparam int COUNT_W = 17;
  localparam int MODE_W  = 2;

  // Frame index space and default map size
  localparam int INDEX_LIMIT    = 65536;
  localparam int MAX_FRAMES_DEF = 65536;

  // Map is stored as words of 64 frame bits
  localparam int WORD_BITS = 64;
  localparam int BIT_W     = 6;

  localparam logic [WORD_BITS-1:0] WORD_ALL_USED = {WORD_BITS{1'b1}};
  localparam logic [COUNT_W-1:0]   COUNT_MAX     = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0]   SPAN_RESET    = COUNT_W'(INDEX_LIMIT);

  // Request modes
  localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ADD     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd3;

  // Position of the lowest set bit (0 when none is set)
  function automatic logic [BIT_W-1:0] first_set(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

// File: src/bfa_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_map: frame bitmap storage
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module bfa_map #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 64
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/bfa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_ctrl: allocator sequencer
// Clears the map after reset, runs read-modify-write for single-frame
// requests and a pipelined word scan for allocation; keeps counts and hint.
// ----------------------------------------------------------------------------
module bfa_ctrl #(
  parameter int MAX_FRAMES = bfa_pkg::MAX_FRAMES_DEF,
  parameter int ADDR_W     = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [bfa_pkg::MODE_W-1:0]   mode,
  input  logic [bfa_pkg::FRAME_W-1:0]  frame_index,
  input  logic [bfa_pkg::COUNT_W-1:0]  span,
  output logic                         mem_we,
  output logic [ADDR_W-1:0]            mem_waddr,
  output logic [bfa_pkg::WORD_BITS-1:0] mem_wdata,
  output logic                         mem_re,
  output logic [ADDR_W-1:0]            mem_raddr,
  input  logic [bfa_pkg::WORD_BITS-1:0] mem_rdata,
  output logic                         done,
  output logic                         ok,
  output logic [bfa_pkg::FRAME_W-1:0]  frame_out,
  output logic [bfa_pkg::COUNT_W-1:0]  usable_total,
  output logic [bfa_pkg::COUNT_W-1:0]  used_total,
  output logic [bfa_pkg::COUNT_W-1:0]  free_total
);
  import bfa_pkg::*;

  localparam int CAP   = (MAX_FRAMES < INDEX_LIMIT) ? MAX_FRAMES : INDEX_LIMIT;
  localparam int WORDS = (CAP + WORD_BITS - 1) / WORD_BITS;

  // State codes
  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_SINGLE = 2'd2;
  localparam logic [1:0] ST_SCAN   = 2'd3;

  logic [1:0]           state;
  logic [MODE_W-1:0]    req_mode;
  logic [FRAME_W-1:0]   req_idx;
  logic [COUNT_W-1:0]   free_count;
  logic [COUNT_W-1:0]   usable_count;
  logic [FRAME_W-1:0]   scan_hint;
  logic [ADDR_W-1:0]    clr_addr;

  // Scan bookkeeping
  logic                 pass1;
  logic [ADDR_W-1:0]    lo_word;
  logic [BIT_W-1:0]     lo_bit;
  logic [ADDR_W-1:0]    last_word;
  logic [BIT_W-1:0]     last_bit;
  logic [ADDR_W-1:0]    raddr;
  logic                 rd_more;
  logic                 pend;
  logic [ADDR_W-1:0]    paddr;

  // Pass bounds
  logic                 p0_empty;
  logic                 p1_empty;
  logic [COUNT_W-1:0]   span_m1;
  logic [COUNT_W-1:0]   p1_hi;
  logic [COUNT_W-1:0]   p1_hi_m1;
  logic                 idx_in_span;

  // Word evaluation
  logic [WORD_BITS-1:0] mask_lo;
  logic [WORD_BITS-1:0] mask_hi;
  logic [WORD_BITS-1:0] cand;
  logic                 hit;
  logic [BIT_W-1:0]     hit_bit;
  logic [FRAME_W-1:0]   hit_frame;
  logic [WORD_BITS-1:0] req_onehot;
  logic                 bit_used;
  logic                 do_release;
  logic                 do_reserve;

  // Bounds of the two scan passes
  always_comb begin
    span_m1     = span - COUNT_W'(1);
    p0_empty    = {1'b0, scan_hint} >= span;
    p1_hi       = ({1'b0, scan_hint} < span) ? {1'b0, scan_hint} : span;
    p1_hi_m1    = p1_hi - COUNT_W'(1);
    p1_empty    = (p1_hi == '0);
    idx_in_span = {1'b0, frame_index} < span;
  end

  // Candidate free bits of the word now returned by the map
  always_comb begin
    mask_lo   = (paddr == lo_word) ? (WORD_ALL_USED << lo_bit) : WORD_ALL_USED;
    mask_hi   = (paddr == last_word) ?
                (WORD_ALL_USED >> (BIT_W'(WORD_BITS - 1) - last_bit)) : WORD_ALL_USED;
    cand      = ~mem_rdata & mask_lo & mask_hi;
    hit       = pend && (cand != '0);
    hit_bit   = first_set(cand);
    hit_frame = FRAME_W'({paddr, hit_bit});
  end

  // Single-frame modify
  always_comb begin
    req_onehot = WORD_BITS'(1) << req_idx[BIT_W-1:0];
    bit_used   = mem_rdata[req_idx[BIT_W-1:0]];
    do_release = ((req_mode == MODE_FREE) || (req_mode == MODE_ADD)) && bit_used;
    do_reserve = (req_mode == MODE_RESERVE) && !bit_used;
  end

  // Map port steering
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = raddr;
    mem_we    = 1'b0;
    mem_waddr = paddr;
    mem_wdata = mem_rdata | (WORD_BITS'(1) << hit_bit);
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = WORD_ALL_USED;
      end
      ST_IDLE: begin
        mem_raddr = frame_index[BIT_W +: ADDR_W];
        mem_re    = start && (mode != MODE_ALLOC) && idx_in_span;
      end
      ST_SINGLE: begin
        mem_waddr = req_idx[BIT_W +: ADDR_W];
        mem_we    = do_release || do_reserve;
        mem_wdata = do_release ? (mem_rdata & ~req_onehot) : (mem_rdata | req_onehot);
      end
      ST_SCAN: begin
        mem_re = rd_more;
        mem_we = hit;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      free_count   <= '0;
      usable_count <= '0;
      scan_hint    <= '0;
      done         <= 1'b0;
      rd_more      <= 1'b0;
      pend         <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        // Mark every frame used, one word a cycle
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(WORDS - 1)) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (start) begin
            req_mode  <= mode;
            req_idx   <= frame_index;
            frame_out <= '0;
            ok        <= 1'b0;
            if (mode == MODE_ALLOC) begin
              if (free_count == '0) begin
                done <= 1'b1;
              end else if (!p0_empty) begin
                state     <= ST_SCAN;
                pass1     <= 1'b0;
                lo_word   <= scan_hint[BIT_W +: ADDR_W];
                lo_bit    <= scan_hint[BIT_W-1:0];
                last_word <= span_m1[BIT_W +: ADDR_W];
                last_bit  <= span_m1[BIT_W-1:0];
                raddr     <= scan_hint[BIT_W +: ADDR_W];
                rd_more   <= 1'b1;
                pend      <= 1'b0;
              end else if (!p1_empty) begin
                state     <= ST_SCAN;
                pass1     <= 1'b1;
                lo_word   <= '0;
                lo_bit    <= '0;
                last_word <= p1_hi_m1[BIT_W +: ADDR_W];
                last_bit  <= p1_hi_m1[BIT_W-1:0];
                raddr     <= '0;
                rd_more   <= 1'b1;
                pend      <= 1'b0;
              end else begin
                done <= 1'b1;
              end
            end else if (idx_in_span) begin
              state <= ST_SINGLE;
            end else begin
              done <= 1'b1;
            end
          end
        end

        // Map word has arrived: update and report
        ST_SINGLE: begin
          if (do_release) begin
            free_count <= (free_count == COUNT_MAX) ? free_count : free_count + COUNT_W'(1);
            if (req_mode == MODE_ADD) begin
              usable_count <= (usable_count == COUNT_MAX) ? usable_count :
                              usable_count + COUNT_W'(1);
            end
            if (req_idx < scan_hint) begin
              scan_hint <= req_idx;
            end
          end
          if (do_reserve && (free_count != '0)) begin
            free_count <= free_count - COUNT_W'(1);
          end
          ok    <= do_release || do_reserve;
          done  <= 1'b1;
          state <= ST_IDLE;
        end

        // One word read and one word checked per cycle
        ST_SCAN: begin
          if (rd_more) begin
            paddr <= raddr;
            pend  <= 1'b1;
            if (raddr == last_word) begin
              rd_more <= 1'b0;
            end else begin
              raddr <= raddr + ADDR_W'(1);
            end
          end else begin
            pend <= 1'b0;
          end
          if (hit) begin
            free_count <= free_count - COUNT_W'(1);
            scan_hint  <= hit_frame + FRAME_W'(1);
            frame_out  <= hit_frame;
            ok         <= 1'b1;
            done       <= 1'b1;
            rd_more    <= 1'b0;
            pend       <= 1'b0;
            state      <= ST_IDLE;
          end else if (pend && (paddr == last_word)) begin
            if (!pass1 && !p1_empty) begin
              // wrap to the frames below the hint
              pass1     <= 1'b1;
              lo_word   <= '0;
              lo_bit    <= '0;
              last_word <= p1_hi_m1[BIT_W +: ADDR_W];
              last_bit  <= p1_hi_m1[BIT_W-1:0];
              raddr     <= '0;
              rd_more   <= 1'b1;
              pend      <= 1'b0;
            end else begin
              done  <= 1'b1;
              pend  <= 1'b0;
              state <= ST_IDLE;
            end
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy         = (state != ST_IDLE);
  assign usable_total = usable_count;
  assign free_total   = free_count;
  assign used_total   = (usable_count > free_count) ? (usable_count - free_count) : '0;

endmodule

// File: src/bitmap_frame_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_frame_allocator: physical frame allocator over a used/free bitmap
// Allocate (next-fit from a hint), free, add usable and reserve of single
// frames, with usable, used and free counts returned on every request.
// ----------------------------------------------------------------------------
// After reset the block clears its map to all-used, one 64-frame word per
// cycle (1024 words at the default size of 65536 frames), and holds busy
// high meanwhile. A request is taken when start is high and busy is low; its
// single result appears on the result ports for exactly one cycle with done
// high and must be captured then. Free, add usable and reserve read their map
// word and write it back (one map read, one write-back). A failed request
// that needs no map access returns the next cycle. Allocate reads the map one
// word per cycle from the hint, wrapping to the frames below the hint when
// nothing is found above it; the word holding the hint can be read in both
// passes, and the single read port of the map sets that pace. frames_spanned
// may only be written while busy is low and no result is outstanding.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator #(
  parameter int MAX_FRAMES = bfa_pkg::MAX_FRAMES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [bfa_pkg::MODE_W-1:0]  mode,
  input  logic [bfa_pkg::FRAME_W-1:0] frame_index,
  input  logic                        cfg_wr_en,
  input  logic [bfa_pkg::COUNT_W-1:0] cfg_wr_data,
  output logic                        done,
  output logic [bfa_pkg::FRAME_W-1:0] frame_out,
  output logic                        ok,
  output logic [bfa_pkg::COUNT_W-1:0] usable_total,
  output logic [bfa_pkg::COUNT_W-1:0] used_total,
  output logic [bfa_pkg::COUNT_W-1:0] free_total
);
  import bfa_pkg::*;

  localparam int CAP    = (MAX_FRAMES < INDEX_LIMIT) ? MAX_FRAMES : INDEX_LIMIT;
  localparam int WORDS  = (CAP + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [COUNT_W-1:0]   frames_spanned;
  logic [COUNT_W-1:0]   span;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [ADDR_W-1:0]    mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  // Span register
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_spanned <= SPAN_RESET;
    end else if (cfg_wr_en) begin
      frames_spanned <= cfg_wr_data;
    end
  end

  // Effective span, capped at the map size
  assign span = (frames_spanned > COUNT_W'(CAP)) ? COUNT_W'(CAP) : frames_spanned;

  bfa_ctrl #(
    .MAX_FRAMES (MAX_FRAMES),
    .ADDR_W     (ADDR_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .frame_index  (frame_index),
    .span         (span),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata),
    .done         (done),
    .ok           (ok),
    .frame_out    (frame_out),
    .usable_total (usable_total),
    .used_total   (used_total),
    .free_total   (free_total)
  );

  bfa_map #(
    .DEPTH  (WORDS),
    .ADDR_W (ADDR_W),
    .DATA_W (WORD_BITS)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// File: src/bfa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_checker: port-level checks for the frame allocator
// Watches reset, result strobe and reported counts over time.
// ----------------------------------------------------------------------------
module bfa_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic                        ok,
  input logic [bfa_pkg::FRAME_W-1:0] frame_out,
  input logic [bfa_pkg::COUNT_W-1:0] usable_total,
  input logic [bfa_pkg::COUNT_W-1:0] used_total
);
  import bfa_pkg::*;

  // Map clearing holds requests off straight after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("block not busy after reset");

  // A result only follows an accepted request or work in progress
  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy) || $past(busy)))
    else $error("result strobe without a request");

  // Failed requests report frame zero
  a_fail_frame_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !ok) |-> (frame_out == '0))
    else $error("failed request reports a frame");

  // Used count never exceeds usable count
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (used_total <= usable_total))
    else $error("used count above usable count");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .ok           (ok),
  .frame_out    (frame_out),
  .usable_total (usable_total),
  .used_total   (used_total)
);

// File: tb/bitmap_frame_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_tb: self-checking bench for the frame allocator
// Drives allocate, free, add usable and reserve requests over a range of map
// spans. A local bitmap predictor works out each reply, and every reply is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_tb;
  import bfa_pkg::*;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam int MAP_SIZE        = (MAX_FRAMES_DEF < INDEX_LIMIT) ? MAX_FRAMES_DEF
                                                                  : INDEX_LIMIT;

  // One reply as the block reports it
  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               ok;
    logic [COUNT_W-1:0] usable;
    logic [COUNT_W-1:0] used;
    logic [COUNT_W-1:0] free_n;
  } alloc_reply_t;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               start       = 1'b0;
  logic [MODE_W-1:0]  mode        = MODE_ALLOC;
  logic [FRAME_W-1:0] frame_index = '0;
  logic               cfg_wr_en   = 1'b0;
  logic [COUNT_W-1:0] cfg_wr_data = '0;
  logic               busy;
  logic               done;
  logic [FRAME_W-1:0] frame_out;
  logic               ok;
  logic [COUNT_W-1:0] usable_total;
  logic [COUNT_W-1:0] used_total;
  logic [COUNT_W-1:0] free_total;

  // Predictor state: 1 marks a used frame
  bit                 frame_used [MAP_SIZE];
  logic [COUNT_W-1:0] free_cnt   = '0;
  logic [COUNT_W-1:0] usable_cnt = '0;
  logic [FRAME_W-1:0] scan_hint  = '0;
  logic [COUNT_W-1:0] span_reg   = SPAN_RESET;

  alloc_reply_t awaited_replies[$];
  int unsigned  live_frames[$];

  int gap_pct    = 0;
  int mismatches = 0;
  int n_requests = 0;
  int n_granted  = 0;
  int n_refused  = 0;
  int n_spans    = 0;
  int idle_run   = 0;

  bitmap_frame_allocator DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .frame_index  (frame_index),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .done         (done),
    .frame_out    (frame_out),
    .ok           (ok),
    .usable_total (usable_total),
    .used_total   (used_total),
    .free_total   (free_total)
  );

  always #1 clk = ~clk;

  initial begin
    foreach (frame_used[i]) frame_used[i] = 1'b1;
  end

  // Next-fit bitmap allocator: apply one request and return its reply
  function automatic alloc_reply_t predict_reply(input logic [MODE_W-1:0] m,
                                                 input logic [FRAME_W-1:0] idx);
    alloc_reply_t r;
    int unsigned  span, wrap_end, f, pick;
    bit           found;
    r     = '0;
    found = 1'b0;
    pick  = 0;
    span  = span_reg;
    if (span > MAP_SIZE) span = MAP_SIZE;
    if (m == MODE_ALLOC) begin
      if (free_cnt != 0) begin
        // hint to span end, then wrap from zero up to the hint
        wrap_end = (scan_hint < span) ? scan_hint : span;
        for (f = scan_hint; f < span && !found; f++) begin
          if (!frame_used[f]) begin
            found = 1'b1;
            pick  = f;
          end
        end
        for (f = 0; f < wrap_end && !found; f++) begin
          if (!frame_used[f]) begin
            found = 1'b1;
            pick  = f;
          end
        end
        if (found) begin
          frame_used[pick] = 1'b1;
          free_cnt         = free_cnt - 1'b1;
          scan_hint        = FRAME_W'(pick + 1);
          r.frame          = FRAME_W'(pick);
          r.ok             = 1'b1;
        end
      end
    end else if (idx < span) begin
      if (m == MODE_FREE || m == MODE_ADD) begin
        if (frame_used[idx]) begin
          frame_used[idx] = 1'b0;
          free_cnt = (free_cnt == COUNT_MAX) ? COUNT_MAX : free_cnt + 1'b1;
          if (m == MODE_ADD) begin
            usable_cnt = (usable_cnt == COUNT_MAX) ? COUNT_MAX : usable_cnt + 1'b1;
          end
          if (idx < scan_hint) scan_hint = idx;
          r.ok = 1'b1;
        end
      end else if (!frame_used[idx]) begin
        // reserve: guarded against a frame already in use
        frame_used[idx] = 1'b1;
        if (free_cnt != 0) free_cnt = free_cnt - 1'b1;
        r.ok = 1'b1;
      end
    end
    r.usable = usable_cnt;
    r.used   = (usable_cnt > free_cnt) ? usable_cnt - free_cnt : '0;
    r.free_n = free_cnt;
    return r;
  endfunction

  // Offer one request, hold it until accepted, then record its prediction
  task automatic issue_request(input logic [MODE_W-1:0] m, input logic [FRAME_W-1:0] idx);
    alloc_reply_t r;
    // sender idles while a draw below gap_pct out of a hundred comes up
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    mode        <= m;
    frame_index <= idx;
    do @(posedge clk); while (busy);
    r = predict_reply(m, idx);
    awaited_replies.push_back(r);
    n_requests++;
    if (m == MODE_ALLOC) begin
      if (r.ok) begin
        n_granted++;
        live_frames.push_back(r.frame);
      end else begin
        n_refused++;
      end
    end
  endtask

  // Stop offering and wait for every outstanding reply
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (awaited_replies.size() != 0 || busy);
  endtask

  // Span register write, only with the block idle
  task automatic set_span(input logic [COUNT_W-1:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    span_reg = v;
    n_spans++;
  endtask

  // Empty map, double free/add, reserve guard, used count floor at zero
  task automatic test_empty_map();
    issue_request(MODE_ALLOC, 16'hFFFF);
    issue_request(MODE_RESERVE, 16'd0);
    issue_request(MODE_ADD, 16'd0);
    issue_request(MODE_ADD, 16'd0);
    issue_request(MODE_FREE, 16'd0);
    issue_request(MODE_ALLOC, 16'd0);
    issue_request(MODE_FREE, 16'd0);
    issue_request(MODE_RESERVE, 16'd0);
    issue_request(MODE_FREE, 16'd1);
    issue_request(MODE_FREE, 16'd2);
    issue_request(MODE_ALLOC, 16'd0);
    issue_request(MODE_ALLOC, 16'd0);
  endtask

  // Hint wrap after the top frame, hint beyond a shrunk span, empty scan
  task automatic test_hint_handling();
    set_span(COUNT_MAX);
    issue_request(MODE_ADD, 16'hFFFF);
    issue_request(MODE_ALLOC, 16'd0);
    issue_request(MODE_ADD, 16'd40000);
    issue_request(MODE_ALLOC, 16'd0);
    issue_request(MODE_ADD, 16'd60000);
    set_span(17'd100);
    issue_request(MODE_ADD, 16'd5);
    issue_request(MODE_ALLOC, 16'd0);
    issue_request(MODE_ALLOC, 16'd0);
  endtask

  // Indices at and above the span are refused, the last index below it is taken
  task automatic test_index_range();
    issue_request(MODE_ADD, 16'hFFFF);
    issue_request(MODE_RESERVE, 16'd100);
    issue_request(MODE_FREE, 16'd99);
  endtask

  // Zero span: nothing in range; one-frame span
  task automatic test_span_extremes();
    set_span(17'd0);
    issue_request(MODE_ADD, 16'd0);
    issue_request(MODE_ALLOC, 16'd0);
    issue_request(MODE_RESERVE, 16'd0);
    set_span(17'd1);
    issue_request(MODE_ADD, 16'd0);
    issue_request(MODE_ADD, 16'd1);
    issue_request(MODE_ALLOC, 16'd0);
  endtask

  // Bursts of mixed requests, each burst on a fresh span (mostly small)
  task automatic test_random_traffic(input int n_items, input int pct);
    int               sent, burst, k;
    int unsigned      span, r;
    logic [MODE_W-1:0]  m;
    logic [FRAME_W-1:0] idx;
    gap_pct = pct;
    sent    = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 10) begin
        span  = INDEX_LIMIT;
        burst = 30;
      end else if (r < 16) begin
        span  = $urandom_range(1, 63);
        burst = 40;
      end else begin
        span  = $urandom_range(64, 2048);
        burst = 70;
      end
      set_span(COUNT_W'(span));
      repeat ((burst < n_items - sent) ? burst : n_items - sent) begin
        r   = $urandom_range(99);
        idx = ($urandom_range(9) == 0) ? FRAME_W'($urandom)
                                       : FRAME_W'($urandom_range(span - 1));
        if (r < 30) begin
          m = MODE_ADD;
        end else if (r < 60) begin
          m   = MODE_ALLOC;
          idx = FRAME_W'($urandom);
        end else if (r < 82) begin
          m = MODE_FREE;
          // mostly give back a frame handed out earlier
          if (live_frames.size() != 0 && $urandom_range(3) != 0) begin
            k   = $urandom_range(live_frames.size() - 1);
            idx = FRAME_W'(live_frames[k]);
            live_frames.delete(k);
          end
        end else begin
          m = MODE_RESERVE;
        end
        issue_request(m, idx);
        sent++;
      end
    end
    drain();
  endtask

  // Reply checker
  always @(posedge clk) begin
    alloc_reply_t e;
    if (!rst && done) begin
      if (awaited_replies.size() == 0) begin
        $error("reply with no request outstanding: frame_out %0d ok %0d", frame_out, ok);
        mismatches++;
      end else begin
        e = awaited_replies.pop_front();
        if (frame_out !== e.frame) begin
          $error("frame_out: expected %0d, got %0d", e.frame, frame_out);
          mismatches++;
        end
        if (ok !== e.ok) begin
          $error("ok: expected %0d, got %0d", e.ok, ok);
          mismatches++;
        end
        if (usable_total !== e.usable) begin
          $error("usable_total: expected %0d, got %0d", e.usable, usable_total);
          mismatches++;
        end
        if (used_total !== e.used) begin
          $error("used_total: expected %0d, got %0d", e.used, used_total);
          mismatches++;
        end
        if (free_total !== e.free_n) begin
          $error("free_total: expected %0d, got %0d", e.free_n, free_total);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles with neither a request taken nor a reply
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
      if (idle_run >= WATCHDOG_CYCLES) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Sequence
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_map();
    test_hint_handling();
    test_index_range();
    test_span_extremes();
    test_random_traffic(615, 24);
    test_random_traffic(615, 74);
    test_random_traffic(615, 0);
    drain();
    repeat (64) @(posedge clk);
    $display("Ran %0d requests over %0d span settings (0, 1, small, full, over-range).",
             n_requests, n_spans);
    $display("Allocations granted %0d, refused %0d; sender gaps 24%%, 74%% and none.",
             n_granted, n_refused);
    if (mismatches == 0 && awaited_replies.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
